// ===== rtl/aes_pkg.sv =====
// Shared types, constants and AES functions for the AES-128 ECB core.
package aes_pkg;

	localparam int NUM_WORDS = 44;
	localparam int NUM_ROUNDS = 10;
	localparam int WORD_AW = 6;
	localparam logic [4:0] BLOCK_BYTES = 5'd16;
	localparam logic [7:0] PAD_FULL = 8'h10;

	typedef enum logic [0:0] {
		CFG_KEY_HIGH = 1'b0,
		CFG_KEY_LOW  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic [4:0]  valid_bytes;
		logic        is_final;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
		logic        last_of_run;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEXP,
		ST_LOAD,
		ST_ROUND,
		ST_OUT
	} state_t;

	// control from sequencer to datapath
	typedef struct packed {
		logic       load;      // load padded state, add round key 0
		logic       load_pad;  // load the full pad block instead
		logic       round;     // run one round
		logic       last_rnd;  // skip mix columns
	} dp_ctrl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		unique case (r)
			4'd0: v = 8'h01;
			4'd1: v = 8'h02;
			4'd2: v = 8'h04;
			4'd3: v = 8'h08;
			4'd4: v = 8'h10;
			4'd5: v = 8'h20;
			4'd6: v = 8'h40;
			4'd7: v = 8'h80;
			4'd8: v = 8'h1b;
			4'd9: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/aes_keyexp.sv =====
// Key expansion sequencer and round-key word memory.
module aes_keyexp
	import aes_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [127:0]       key,
	input  logic               start,      // begin a new expansion
	output logic               busy,
	input  logic [3:0]         rk_round,   // round key to read
	output logic [127:0]       rk_data     // registered, next cycle
);

	logic [127:0] rk_mem [NUM_ROUNDS + 1];
	logic [127:0] cur_q;
	logic [3:0]   cnt_q;
	logic         busy_q;
	logic [31:0]  t_word;
	logic [127:0] nxt;

	// one round key (four words) per cycle
	always_comb begin
		t_word = {sbox(cur_q[23:16]), sbox(cur_q[15:8]), sbox(cur_q[7:0]),
			sbox(cur_q[31:24])} ^ {rcon(cnt_q), 24'h0};
		nxt[127:96] = cur_q[127:96] ^ t_word;
		nxt[95:64]  = cur_q[95:64] ^ nxt[127:96];
		nxt[63:32]  = cur_q[63:32] ^ nxt[95:64];
		nxt[31:0]   = cur_q[31:0] ^ nxt[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(NUM_ROUNDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// round-key memory: write one entry per cycle, registered read
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q     <= key;
			rk_mem[0] <= key;
		end else if (busy_q) begin
			cur_q <= nxt;
			rk_mem[cnt_q + 4'd1] <= nxt;
		end
		rk_data <= rk_mem[rk_round];
	end

	assign busy = busy_q;

endmodule

// ===== rtl/aes_round.sv =====
// Shared AES round unit and block state register.
module aes_round
	import aes_pkg::*;
(
	input  logic         clk,
	input  dp_ctrl_t     ctrl,
	input  in_beat_t     din,
	input  logic [127:0] rk,
	output logic [127:0] state
);

	logic [127:0] st_q;
	logic [127:0] loaded;
	logic [127:0] sb, sr, mc, rnd;
	logic [4:0]   vcnt;

	function automatic logic [7:0] sbyte(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	// apply padding to the incoming block
	always_comb begin
		vcnt = (din.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : din.valid_bytes;
		loaded = {din.block_high, din.block_low};
		for (int i = 0; i < 16; i++) begin
			if (ctrl.load_pad) begin
				loaded[127 - 8*i -: 8] = PAD_FULL;
			end else if (din.is_final && (5'(i) >= vcnt)) begin
				loaded[127 - 8*i -: 8] = {3'b000, BLOCK_BYTES - vcnt};
			end
		end
	end

	// sub bytes, shift rows, mix columns (skipped in the last round), add round key
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sb[127 - 8*i -: 8] = sbox(sbyte(st_q, i));
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sr[127 - 8*(r + 4*c) -: 8] = sbyte(sb, r + 4*((c + r) % 4));
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sbyte(sr, 4*c);
			a1 = sbyte(sr, 4*c + 1);
			a2 = sbyte(sr, 4*c + 2);
			a3 = sbyte(sr, 4*c + 3);
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
				a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
		end
		rnd = (ctrl.last_rnd ? sr : mc) ^ rk;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			st_q <= loaded ^ rk;
		end else if (ctrl.round) begin
			st_q <= rnd;
		end
	end

	assign state = st_q;

endmodule

// ===== rtl/aes128_ecb_encrypt_pkcs7_core.sv =====
// Top level of the AES-128 ECB encryption core with PKCS#7 padding.
// Each accepted block goes through one shared round unit: round key 0 is
// fetched, then the block is loaded and the key added, then ten rounds run,
// and the result sits in the block state register until taken, after which
// the core is ready again. A full final block causes a second pass over the
// pad block. The first block after reset or a key write first expands the key,
// one round key per cycle into a small memory.
module aes128_ecb_encrypt_pkcs7_core
	import aes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data
);

	logic [63:0] key_hi_q, key_lo_q;
	logic        keys_ready_q;
	in_beat_t    blk_q;
	state_t      st_q, st_d;
	logic [3:0]  rnd_q;
	logic        pad_pass_q;
	logic        kx_busy, kx_start;
	logic [127:0] rk, dp_state;
	dp_ctrl_t    ctrl;
	logic        accept, full_final;

	assign accept = in_valid && in_ready;
	assign full_final = blk_q.is_final && (blk_q.valid_bytes >= BLOCK_BYTES);

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q     <= '0;
			key_lo_q     <= '0;
			keys_ready_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_HIGH: key_hi_q <= cfg_wdata;
				CFG_KEY_LOW:  key_lo_q <= cfg_wdata;
				default: ;
			endcase
			keys_ready_q <= 1'b0;
		end else if (kx_start) begin
			keys_ready_q <= 1'b1;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (accept) st_d = keys_ready_q ? ST_LOAD : ST_KEXP;
			ST_KEXP:  if (!kx_busy && !kx_start) st_d = ST_LOAD;
			ST_LOAD:  st_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 4'(NUM_ROUNDS)) st_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) st_d = (full_final && !pad_pass_q) ? ST_LOAD : ST_IDLE;
			end
			default:  st_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		kx_start      = (st_q == ST_IDLE) && accept && !keys_ready_q;
		ctrl.load     = (st_q == ST_LOAD);
		ctrl.load_pad = pad_pass_q;
		ctrl.round    = (st_q == ST_ROUND);
		ctrl.last_rnd = (rnd_q == 4'(NUM_ROUNDS));
		in_ready      = (st_q == ST_IDLE);
		out_valid     = (st_q == ST_OUT);
	end

	// state, pad-pass flag and round counter; the counter also feeds the key read address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			rnd_q      <= '0;
			pad_pass_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE) begin
				pad_pass_q <= 1'b0;
			end else if (st_q == ST_OUT && out_ready) begin
				pad_pass_q <= 1'b1;
			end
			if (st_d == ST_LOAD) begin
				rnd_q <= '0;
			end else if (st_q == ST_LOAD || st_q == ST_ROUND) begin
				rnd_q <= rnd_q + 4'd1;
			end
		end
	end

	// hold the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= in_data;
		end
	end

	// read address follows the next state, so the registered key is ready when used
	logic [3:0] rk_addr;
	assign rk_addr = (st_d == ST_LOAD) ? 4'd0 :
		((st_q == ST_LOAD || st_q == ST_ROUND) ? rnd_q + 4'd1 : rnd_q);

	aes_keyexp u_kexp (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      ({key_hi_q, key_lo_q}),
		.start    (kx_start),
		.busy     (kx_busy),
		.rk_round (rk_addr),
		.rk_data  (rk)
	);

	aes_round u_round (
		.clk   (clk),
		.ctrl  (ctrl),
		.din   (blk_q),
		.rk    (rk),
		.state (dp_state)
	);

	assign out_data.cipher_high = dp_state[127:64];
	assign out_data.cipher_low  = dp_state[63:0];
	assign out_data.last_of_run = !(full_final && !pad_pass_q);

endmodule
